@@ design/lldpbcp_pkg.sv @@
package lldpbcp_pkg;

   // tick counter width
   localparam int TICK_W = 32;
   localparam int TIMEOUT_W = 32;
   localparam int CMP_W = (TICK_W > TIMEOUT_W) ? TICK_W : TIMEOUT_W;

   localparam int OUI_W = 24;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;

   // item kinds carried on req_tuser
   localparam logic [1:0] ACT_BYTE = 2'd0;
   localparam logic [1:0] ACT_TICK = 2'd1;
   localparam logic [1:0] ACT_START = 2'd2;

   // result kinds carried on rsp_tuser
   localparam logic [1:0] OUT_FRAME = 2'd0;
   localparam logic [1:0] OUT_CHANGED = 2'd1;
   localparam logic [1:0] OUT_TIMEOUT = 2'd2;

   // configuration register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_OUI_PRIMARY = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_OUI_SECONDARY = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_TIMEOUT = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_INIT_BOND = 2'd3;

   // parser phases
   localparam logic [2:0] PH_HDR0 = 3'd0;
   localparam logic [2:0] PH_HDR1 = 3'd1;
   localparam logic [2:0] PH_ORG = 3'd2;
   localparam logic [2:0] PH_SKIP = 3'd3;
   localparam logic [2:0] PH_DONE = 3'd4;

   localparam logic [6:0] ORG_TYPE = 7'd127;
   localparam logic [8:0] CFG_TLV_LEN = 9'd8;
   localparam logic [7:0] CFG_SUBTYPE = 8'h01;
   localparam logic [2:0] BOND_MASK = 3'h7;

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] data_byte;
      logic last_byte;
   } lldpbcp_item_type;

   typedef struct packed {
      logic has_rsp;
      logic [1:0] outcome;
      logic bonding;
   } lldpbcp_rsp_type;

   typedef struct packed {
      logic [OUI_W-1:0] oui_primary;
      logic [OUI_W-1:0] oui_secondary;
      logic [TIMEOUT_W-1:0] timeout_ticks;
      logic initial_bonding;
   } lldpbcp_cfg_type;

endpackage

@@ design/lldpbcp_core.sv @@
module lldpbcp_core
   import lldpbcp_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic fire,
   input  lldpbcp_item_type item,
   input  lldpbcp_cfg_type cfg,
   output lldpbcp_rsp_type rsp
);

   logic bond_ff, bond_in;
   logic seen_ff, seen_in;
   logic [TICK_W-1:0] tick_ff, tick_in;
   logic [2:0] phase_ff, phase_in;
   logic [6:0] type_ff, type_in;
   logic [8:0] rem_ff, rem_in;
   logic [OUI_W-1:0] oui_ff, oui_in;
   logic changed_ff, changed_in;

   logic [3:0] idx;
   logic [TICK_W-1:0] tick_inc;
   logic oui_hit;

   assign idx = 4'(CFG_TLV_LEN) - rem_ff[3:0];
   assign tick_inc = (&tick_ff) ? tick_ff : tick_ff + TICK_W'(1);
   assign oui_hit = (oui_ff == cfg.oui_primary) || (oui_ff == cfg.oui_secondary);

   always_comb begin
      bond_in = bond_ff;
      seen_in = seen_ff;
      tick_in = tick_ff;
      phase_in = phase_ff;
      type_in = type_ff;
      rem_in = rem_ff;
      oui_in = oui_ff;
      changed_in = changed_ff;
      rsp = '0;
      case (item.action)
         ACT_BYTE: begin
            case (phase_ff)
               PH_HDR1: begin
                  rem_in = {rem_ff[8], item.data_byte};
                  if (type_ff == 7'd0 && rem_in == 9'd0) begin
                     phase_in = PH_DONE;
                  end else if (rem_in == 9'd0) begin
                     phase_in = PH_HDR0;
                  end else if (type_ff == ORG_TYPE && rem_in == CFG_TLV_LEN) begin
                     oui_in = '0;
                     phase_in = PH_ORG;
                  end else begin
                     phase_in = PH_SKIP;
                  end
               end
               PH_ORG: begin
                  if (idx == 4'd7) begin
                     seen_in = 1'b1;
                     rem_in = '0;
                     if ((&item.data_byte[2:0]) != bond_ff) begin
                        bond_in = &(item.data_byte[2:0] & BOND_MASK);
                        changed_in = 1'b1;
                        phase_in = PH_DONE;
                     end else begin
                        phase_in = PH_HDR0;
                     end
                  end else begin
                     if (idx < 4'd3) begin
                        oui_in = {oui_ff[OUI_W-9:0], item.data_byte};
                     end else if (idx == 4'd3) begin
                        if (item.data_byte != CFG_SUBTYPE || !oui_hit) begin
                           phase_in = PH_SKIP;
                        end
                     end
                     rem_in = rem_ff - 9'd1;
                     if (rem_in == 9'd0) begin
                        phase_in = PH_HDR0;
                     end
                  end
               end
               PH_SKIP: begin
                  rem_in = rem_ff - 9'd1;
                  if (rem_in == 9'd0) begin
                     phase_in = PH_HDR0;
                  end
               end
               PH_DONE: begin
               end
               default: begin
                  type_in = item.data_byte[7:1];
                  rem_in = {item.data_byte[0], 8'd0};
                  phase_in = PH_HDR1;
               end
            endcase
            if (item.last_byte) begin
               rsp.has_rsp = 1'b1;
               rsp.outcome = changed_in ? OUT_CHANGED : OUT_FRAME;
               rsp.bonding = bond_in;
               phase_in = PH_HDR0;
               type_in = '0;
               rem_in = '0;
               oui_in = '0;
               changed_in = 1'b0;
            end
         end
         ACT_TICK: begin
            tick_in = tick_inc;
            if (!seen_ff && bond_ff &&
                CMP_W'(tick_inc) >= CMP_W'(cfg.timeout_ticks)) begin
               bond_in = 1'b0;
               rsp.has_rsp = 1'b1;
               rsp.outcome = OUT_TIMEOUT;
               rsp.bonding = 1'b0;
            end
         end
         ACT_START: begin
            bond_in = cfg.initial_bonding;
            seen_in = 1'b0;
            tick_in = '0;
            phase_in = PH_HDR0;
            type_in = '0;
            rem_in = '0;
            oui_in = '0;
            changed_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bond_ff <= 1'b0;
         seen_ff <= 1'b0;
         tick_ff <= '0;
         phase_ff <= PH_HDR0;
         type_ff <= '0;
         rem_ff <= '0;
         oui_ff <= '0;
         changed_ff <= 1'b0;
      end else if (fire) begin
         bond_ff <= bond_in;
         seen_ff <= seen_in;
         tick_ff <= tick_in;
         phase_ff <= phase_in;
         type_ff <= type_in;
         rem_ff <= rem_in;
         oui_ff <= oui_in;
         changed_ff <= changed_in;
      end
   end

endmodule

@@ design/lldp_org_tlv_bond_config_parser_core.sv @@
// LLDP organizational TLV bond configuration parser.
//
// req_* carries one beat per item: a frame byte, a time tick or a start
// command (kind on req_tuser, byte on req_tdata, end of frame on req_tlast).
// rsp_* carries at most one result per item: the kind of result on rsp_tuser
// and the bond setting after the item on rsp_tdata[0]. A frame's last byte
// always yields a result; a tick yields one only when it clears the bond
// setting; a start yields none.
// csr_* writes the OUIs, the tick timeout and the initial bond value; write
// only while no item is in flight.
//
// rsp_tvalid rises once the result is registered: the beat lands in the
// input register at the accept edge, then the parse and tick logic runs
// combinationally into the result register, loaded when the item fires.
// One item is taken per cycle as long as results drain; the result register
// lets a new item enter while an earlier result waits. When rsp_tready is low
// and a result is held, an item that would also give a result waits in the
// input register and req_tready drops; items without a result still pass.
// Synchronous reset clears control state and config; no result is pending.
module lldp_org_tlv_bond_config_parser_core
   import lldpbcp_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic req_tlast,
   input  logic [1:0] req_tuser,   // [1:0] action
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [7:0] rsp_tdata,   // [0] bonding, [7:1] zero
   output logic [1:0] rsp_tuser,   // [1:0] outcome
   input  logic csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic s1_valid_ff, s1_valid_in;
   lldpbcp_item_type s1_item_ff;
   logic rsp_valid_ff, rsp_valid_in;
   logic [1:0] rsp_outcome_ff;
   logic rsp_bonding_ff;
   lldpbcp_cfg_type cfg_ff;
   lldpbcp_rsp_type res;
   logic out_free;
   logic fire;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign fire = s1_valid_ff && (!res.has_rsp || out_free);
   assign req_tready = !s1_valid_ff || fire;

   assign s1_valid_in = (req_tvalid && req_tready) || (s1_valid_ff && !fire);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire && res.has_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   lldpbcp_core u_core (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .item  (s1_item_ff),
      .cfg   (cfg_ff),
      .rsp   (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload: load input beat, load result
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_item_ff.action <= req_tuser;
         s1_item_ff.data_byte <= req_tdata;
         s1_item_ff.last_byte <= req_tlast;
      end
      if (fire && res.has_rsp) begin
         rsp_outcome_ff <= res.outcome;
         rsp_bonding_ff <= res.bonding;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_OUI_PRIMARY: cfg_ff.oui_primary <= csr_wdata[OUI_W-1:0];
            CSR_OUI_SECONDARY: cfg_ff.oui_secondary <= csr_wdata[OUI_W-1:0];
            CSR_TIMEOUT: cfg_ff.timeout_ticks <= csr_wdata[TIMEOUT_W-1:0];
            CSR_INIT_BOND: cfg_ff.initial_bonding <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser = rsp_outcome_ff;
   assign rsp_tdata = {7'd0, rsp_bonding_ff};

   a_timeout_clears : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == OUT_TIMEOUT |-> rsp_tdata[0] == 1'b0)
      else $error("timeout result with bond set");

   a_stall_holds : assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !fire |=> s1_valid_ff && $stable(s1_item_ff))
      else $error("stalled item lost");

   a_result_lands : assert property (@(posedge clock) disable iff (reset)
      fire && res.has_rsp |=> rsp_tvalid)
      else $error("result not registered");

   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !(fire && res.has_rsp))
      else $error("pending result overwritten");

endmodule
